FILE: hdl/nmea_pkg.sv
// ----------------------------------------------------------------------------
// nmea_pkg: shared types, constants and functions for the NMEA sentence checker
// Holds the line-scan phase encoding, the result record, the character
// constants and the header table that maps a line header to a sentence kind.
// ----------------------------------------------------------------------------
package nmea_pkg;

   // Default sizing of the line store and the star search window
   localparam int LINE_BYTES_DEF = 128;
   localparam int SCAN_LIMIT_DEF = 75;

   // Character codes
   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_NUL    = 8'h00;

   // Sentence kind codes
   localparam logic [2:0] KIND_NONE = 3'd0;
   localparam int         KIND_COUNT = 6;

   // Header bytes 1..5 of each known sentence, byte 1 in the lowest bits.
   // Strings are written reversed so the first header char lands in bits 7:0.
   localparam logic [KIND_COUNT-1:0][39:0] KIND_HEADS = '{
      "LLGNG",   // $GNGLL -> kind 6
      "CMRNG",   // $GNRMC -> kind 5
      "AGGNG",   // $GNGGA -> kind 4
      "LLGPG",   // $GPGLL -> kind 3
      "CMRPG",   // $GPRMC -> kind 2
      "AGGPG"    // $GPGGA -> kind 1
   };

   // Scan phase of the line being received
   typedef enum logic [5:0] {
      PH_AWAIT  = 6'b000001,
      PH_SUM    = 6'b000010,
      PH_HEXH   = 6'b000100,
      PH_HEXL   = 6'b001000,
      PH_DONE   = 6'b010000,
      PH_REJECT = 6'b100000
   } phase_type;

   // One line result
   typedef struct packed {
      logic       checksum_ok;
      logic [2:0] sentence_kind;
      logic [7:0] computed_xor;
      logic [7:0] line_length;
      logic       ended_by_overflow;
   } result_type;

   // Uppercase hex character for one nibble
   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] wide;
      wide = {4'h0, v};
      return (v < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
   endfunction

   // First matching header wins; no match gives KIND_NONE
   function automatic logic [2:0] header_kind(input logic [39:0] head);
      logic [2:0] kind;
      kind = KIND_NONE;
      for (int k = KIND_COUNT - 1; k >= 0; k--) begin
         if (head == KIND_HEADS[k]) begin
            kind = 3'(k + 1);
         end
      end
      return kind;
   endfunction

endpackage

FILE: hdl/nmea_sentence_checker_unit.sv
// Path: a byte that ends a line gives its result on rsp through the input register,
//    then the result register.
// Throughput: one byte per cycle, set by the scan update; a
//    line result waiting on rsp stalls only a following line-ending byte.
// Reset: synchronous, active high; clears the line state and both valid flags.
// ----------------------------------------------------------------------------
// nmea_sentence_checker_unit: NMEA 0183 sentence checksum checker
// Gathers received bytes into lines and reports, per line, the checksum
// verdict, the sentence kind, the computed XOR, the length and overflow.
// ----------------------------------------------------------------------------
module nmea_sentence_checker_unit #(
   parameter int LINE_BYTES = nmea_pkg::LINE_BYTES_DEF,
   parameter int SCAN_LIMIT = nmea_pkg::SCAN_LIMIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] checksum_ok, [8:1] computed_xor,
                                    // [16:9] line_length, [17] ended_by_overflow
   output logic [2:0]  rsp_tuser    // [2:0] sentence_kind
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff,  in_byte_in;
   logic                 out_valid_ff, out_valid_in;
   nmea_pkg::result_type out_res_ff,   out_res_in;
   logic                 line_end;
   logic                 out_free;
   logic                 fire;
   nmea_pkg::result_type scan_res;

   nmea_scan #(
      .LINE_BYTES (LINE_BYTES),
      .SCAN_LIMIT (SCAN_LIMIT)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .rx_byte  (in_byte_ff),
      .line_end (line_end),
      .result   (scan_res)
   );

   // Byte moves on unless it needs the result slot and that slot is busy
   assign out_free   = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && (!line_end || out_free);
   assign req_tready = !in_valid_ff || fire;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (fire && line_end) begin
         out_valid_in = 1'b1;
         out_res_in   = scan_res;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_res_ff <= out_res_in;
   end

   // Output packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_res_ff.ended_by_overflow, out_res_ff.line_length,
                        out_res_ff.computed_xor, out_res_ff.checksum_ok};
   assign rsp_tuser  = out_res_ff.sentence_kind;

endmodule

FILE: hdl/nmea_scan.sv
// ----------------------------------------------------------------------------
// nmea_scan: per-byte line scanner
// Keeps the running state of the line being received, updates it for one
// byte per transaction and forms the line result when the line ends.
// ----------------------------------------------------------------------------
module nmea_scan #(
   parameter int LINE_BYTES = nmea_pkg::LINE_BYTES_DEF,
   parameter int SCAN_LIMIT = nmea_pkg::SCAN_LIMIT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,       // consume byte this cycle
   input  logic [7:0]           rx_byte,
   output logic                 line_end,   // byte ends the line
   output nmea_pkg::result_type result
);

   localparam int CNT_W = $clog2(LINE_BYTES + 1);

   logic [CNT_W-1:0]    count_ff,  count_in;
   nmea_pkg::phase_type phase_ff,  phase_in;
   logic [7:0]          xor_ff,    xor_in;
   logic [7:0]          hexh_ff,   hexh_in;
   logic [7:0]          hexl_ff,   hexl_in;
   logic [39:0]         header_ff, header_in;
   logic                full;
   logic                hex_seen;

   assign full     = (count_ff == CNT_W'(LINE_BYTES));
   assign line_end = (rx_byte == nmea_pkg::CHAR_NL) || full;

   // Next state for one consumed byte
   always_comb begin
      count_in  = count_ff;
      phase_in  = phase_ff;
      xor_in    = xor_ff;
      hexh_in   = hexh_ff;
      hexl_in   = hexl_ff;
      header_in = header_ff;
      if (fire) begin
         if (line_end) begin
            count_in  = '0;
            phase_in  = nmea_pkg::PH_AWAIT;
            xor_in    = '0;
            hexh_in   = '0;
            hexl_in   = '0;
            header_in = '0;
         end else begin
            count_in = count_ff + 1'b1;
            unique case (phase_ff)
               nmea_pkg::PH_AWAIT: begin
                  phase_in = (rx_byte == nmea_pkg::CHAR_DOLLAR) ?
                             nmea_pkg::PH_SUM : nmea_pkg::PH_REJECT;
               end
               nmea_pkg::PH_SUM: begin
                  if (count_ff >= CNT_W'(SCAN_LIMIT) || rx_byte == nmea_pkg::CHAR_NUL) begin
                     phase_in = nmea_pkg::PH_REJECT;
                  end else if (rx_byte == nmea_pkg::CHAR_STAR) begin
                     phase_in = nmea_pkg::PH_HEXH;
                  end else begin
                     xor_in = xor_ff ^ rx_byte;
                  end
               end
               nmea_pkg::PH_HEXH: begin
                  hexh_in  = rx_byte;
                  phase_in = nmea_pkg::PH_HEXL;
               end
               nmea_pkg::PH_HEXL: begin
                  hexl_in  = rx_byte;
                  phase_in = nmea_pkg::PH_DONE;
               end
               default: begin
               end
            endcase
            // capture header bytes 1..5
            for (int k = 1; k <= 5; k++) begin
               if (count_ff == CNT_W'(k)) begin
                  header_in[8*(k-1) +: 8] = rx_byte;
               end
            end
         end
      end
   end

   // Line result, valid when line_end is high
   assign hex_seen = (phase_ff == nmea_pkg::PH_HEXH) || (phase_ff == nmea_pkg::PH_HEXL) ||
                     (phase_ff == nmea_pkg::PH_DONE);

   always_comb begin
      result.checksum_ok = hex_seen &&
                           (hexh_ff == nmea_pkg::hex_digit(xor_ff[7:4])) &&
                           (hexl_ff == nmea_pkg::hex_digit(xor_ff[3:0]));
      result.sentence_kind     = result.checksum_ok ? nmea_pkg::header_kind(header_ff) :
                                                      nmea_pkg::KIND_NONE;
      result.computed_xor      = xor_ff;
      result.line_length       = 8'(count_ff);
      result.ended_by_overflow = full;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         phase_ff  <= nmea_pkg::PH_AWAIT;
         xor_ff    <= '0;
         hexh_ff   <= '0;
         hexl_ff   <= '0;
         header_ff <= '0;
      end else begin
         count_ff  <= count_in;
         phase_ff  <= phase_in;
         xor_ff    <= xor_in;
         hexh_ff   <= hexh_in;
         hexl_ff   <= hexl_in;
         header_ff <= header_in;
      end
   end

endmodule

FILE: hdl/nmea_checker.sv
// ----------------------------------------------------------------------------
// nmea_checker: port-level checks for the NMEA sentence checker
// Watches the top-level ports and flags result transactions that break the
// stream rules or carry inconsistent line results.
// ----------------------------------------------------------------------------
module nmea_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transaction dropped or changed while stalled");

   // Nothing is offered right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // A failed line never reports a sentence kind
   a_kind_needs_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tuser == 3'd0)
      else $error("sentence kind on a failed line");

   // A passing line holds at least the dollar, star and two hex characters
   a_ok_length: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[16:9] >= 8'd4)
      else $error("checksum pass on a line too short");

   // Unused pad bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:18] == 6'd0)
      else $error("rsp_tdata pad bits set");

endmodule

bind nmea_sentence_checker_unit nmea_checker u_nmea_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: tb/tb_nmea_sentence_checker_unit.sv
// ----------------------------------------------------------------------------
// tb_nmea_sentence_checker_unit: self-checking bench for the sentence checker
// Streams bytes into the checker, predicts each line result with a
// behavioral scan of the same framing and checksum rules, and compares every
// result transaction field by field. Directed lines cover every header, the
// framing faults, the star window edge and line store overflow; random
// lines follow under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_nmea_sentence_checker_unit;

   typedef logic [7:0] byte_seq_type[$];

   // Sentence kind codes as reported on rsp_tuser
   localparam logic [2:0] KIND_GPGGA = 3'd1;
   localparam logic [2:0] KIND_GPRMC = 3'd2;
   localparam logic [2:0] KIND_GPGLL = 3'd3;
   localparam logic [2:0] KIND_GNGGA = 3'd4;
   localparam logic [2:0] KIND_GNRMC = 3'd5;
   localparam logic [2:0] KIND_GNGLL = 3'd6;

   // How the checksum part of a generated sentence is written
   localparam int TAIL_GOOD  = 0;
   localparam int TAIL_BAD   = 1;
   localparam int TAIL_LOWER = 2;
   localparam int TAIL_ONE   = 3;
   localparam int TAIL_NONE  = 4;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;            // [0] checksum_ok, [8:1] computed_xor,
                                      // [16:9] line_length, [17] ended_by_overflow
   logic [2:0]  rsp_tuser;            // [2:0] sentence_kind

   string kind_heads [6] = '{"GPGGA", "GPRMC", "GPGLL", "GNGGA", "GNRMC", "GNGLL"};

   // Predicted line state
   logic [7:0]          line_count;
   nmea_pkg::phase_type scan_ph;
   logic [7:0]          sum_xor;
   logic [7:0]          star_hi;
   logic [7:0]          star_lo;
   logic [39:0]         head_text;   // header bytes 1..5, first byte in the top bits

   nmea_pkg::result_type expected_lines[$];

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int bytes_sent    = 0;
   int lines_checked = 0;
   int good_lines    = 0;
   int overflow_lines = 0;
   int mismatch_count = 0;

   nmea_sentence_checker_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // Watchdog
   initial begin
      #1000000;
      $display("FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // Line scan prediction
   // ------------------------------------------------------------------
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h41 + {4'h0, n} - 8'd10);
   endfunction

   function automatic logic [2:0] kind_of(input logic [39:0] h);
      case (h)
         "GPGGA":  return KIND_GPGGA;
         "GPRMC":  return KIND_GPRMC;
         "GPGLL":  return KIND_GPGLL;
         "GNGGA":  return KIND_GNGGA;
         "GNRMC":  return KIND_GNRMC;
         "GNGLL":  return KIND_GNGLL;
         default:  return nmea_pkg::KIND_NONE;
      endcase
   endfunction

   function automatic void clear_line_state();
      line_count = 8'd0;
      scan_ph    = nmea_pkg::PH_AWAIT;
      sum_xor    = 8'd0;
      star_hi    = 8'd0;
      star_lo    = 8'd0;
      head_text  = 40'd0;
   endfunction

   // Advances the line state by one byte; returns 1 with the line result
   // when the byte ends the line
   function automatic bit scan_rx_byte(input logic [7:0] b,
                                       output nmea_pkg::result_type res);
      logic full;
      bit   ok;
      full = (line_count >= nmea_pkg::LINE_BYTES_DEF);
      res  = '0;
      if (b != nmea_pkg::CHAR_NL && !full) begin
         case (scan_ph)
            nmea_pkg::PH_AWAIT: begin
               scan_ph = (b == nmea_pkg::CHAR_DOLLAR) ? nmea_pkg::PH_SUM :
                                                         nmea_pkg::PH_REJECT;
            end
            nmea_pkg::PH_SUM: begin
               if (line_count >= nmea_pkg::SCAN_LIMIT_DEF || b == nmea_pkg::CHAR_NUL)
                  scan_ph = nmea_pkg::PH_REJECT;
               else if (b == nmea_pkg::CHAR_STAR) scan_ph = nmea_pkg::PH_HEXH;
               else sum_xor = sum_xor ^ b;
            end
            nmea_pkg::PH_HEXH: begin
               star_hi = b;
               scan_ph = nmea_pkg::PH_HEXL;
            end
            nmea_pkg::PH_HEXL: begin
               star_lo = b;
               scan_ph = nmea_pkg::PH_DONE;
            end
            default: ;
         endcase
         if (line_count >= 8'd1 && line_count <= 8'd5) head_text = {head_text[31:0], b};
         line_count = line_count + 8'd1;
         return 0;
      end
      // a missing hex byte stays zero and never matches a digit
      ok = (scan_ph inside {nmea_pkg::PH_HEXH, nmea_pkg::PH_HEXL, nmea_pkg::PH_DONE})
           && star_hi == hex_char(sum_xor[7:4]) && star_lo == hex_char(sum_xor[3:0]);
      res.checksum_ok       = ok;
      res.sentence_kind     = ok ? kind_of(head_text) : nmea_pkg::KIND_NONE;
      res.computed_xor      = sum_xor;
      res.line_length       = line_count;
      res.ended_by_overflow = full;
      clear_line_state();
      return 1;
   endfunction

   // ------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b);
      nmea_pkg::result_type res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      if (scan_rx_byte(b, res)) expected_lines.push_back(res);
   endtask

   task automatic send_bytes(input byte_seq_type seq);
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   function automatic byte_seq_type to_seq(input string s);
      byte_seq_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   // '$', text, '*' and the checksum written as the tail mode asks
   function automatic byte_seq_type build_sentence(input byte_seq_type text, input int tail);
      byte_seq_type q;
      logic [7:0]   x;
      logic [7:0]   c;
      x = 8'd0;
      q.push_back(nmea_pkg::CHAR_DOLLAR);
      foreach (text[i]) begin
         x = x ^ text[i];
         q.push_back(text[i]);
      end
      q.push_back(nmea_pkg::CHAR_STAR);
      case (tail)
         TAIL_GOOD: begin
            q.push_back(hex_char(x[7:4]));
            q.push_back(hex_char(x[3:0]));
         end
         TAIL_BAD: begin
            q.push_back(hex_char(x[7:4]));
            q.push_back(hex_char(x[3:0] ^ 4'h1));
         end
         TAIL_LOWER: begin
            for (int k = 1; k >= 0; k--) begin
               c = hex_char(x[4*k +: 4]);
               if (c >= "A") c = c | 8'h20;
               q.push_back(c);
            end
         end
         TAIL_ONE: q.push_back(hex_char(x[7:4]));
         default: ;
      endcase
      return q;
   endfunction

   task automatic send_sentence(input byte_seq_type text, input int tail, input bit crlf);
      byte_seq_type q;
      q = build_sentence(text, tail);
      if (crlf) q.push_back(CHAR_CR);
      q.push_back(nmea_pkg::CHAR_NL);
      send_bytes(q);
   endtask

   // Printable body text; stars become commas, some high bytes mixed in
   function automatic byte_seq_type rand_text(input int len);
      byte_seq_type q;
      logic [7:0]   c;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 8) c = 8'($urandom_range(128, 255));
         else c = 8'($urandom_range(32, 126));
         if (c == nmea_pkg::CHAR_STAR) c = CHAR_COMMA;
         q.push_back(c);
      end
      return q;
   endfunction

   // Known header, near miss of one, or random letters
   function automatic byte_seq_type rand_header();
      byte_seq_type q;
      int           pick;
      pick = $urandom_range(0, 7);
      if (pick < 6) return to_seq(kind_heads[pick]);
      if (pick == 6) begin
         q = to_seq(kind_heads[$urandom_range(0, 5)]);
         q[$urandom_range(0, 4)] = 8'($urandom_range(65, 90));
         return q;
      end
      for (int i = 0; i < 5; i++) q.push_back(8'($urandom_range(65, 90)));
      return q;
   endfunction

   function automatic byte_seq_type rand_noise(input int len);
      byte_seq_type q;
      for (int i = 0; i < len; i++) q.push_back(8'($urandom_range(0, 255)));
      return q;
   endfunction

   // ------------------------------------------------------------------
   // Result checker
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at line %0d: %s got 0x%0h expected 0x%0h",
               lines_checked, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_result();
      nmea_pkg::result_type want;
      if (expected_lines.size() == 0) begin
         report_mismatch("result with no line pending", rsp_tdata, 0);
         return;
      end
      want = expected_lines.pop_front();
      lines_checked++;
      if (want.checksum_ok) good_lines++;
      if (want.ended_by_overflow) overflow_lines++;
      if (rsp_tdata[0] !== want.checksum_ok)
         report_mismatch("checksum_ok", rsp_tdata[0], want.checksum_ok);
      if (rsp_tuser !== want.sentence_kind)
         report_mismatch("sentence_kind", rsp_tuser, want.sentence_kind);
      if (rsp_tdata[8:1] !== want.computed_xor)
         report_mismatch("computed_xor", rsp_tdata[8:1], want.computed_xor);
      if (rsp_tdata[16:9] !== want.line_length)
         report_mismatch("line_length", rsp_tdata[16:9], want.line_length);
      if (rsp_tdata[17] !== want.ended_by_overflow)
         report_mismatch("ended_by_overflow", rsp_tdata[17], want.ended_by_overflow);
      if (rsp_tdata[23:18] !== 6'd0)
         report_mismatch("tdata padding", rsp_tdata[23:18], 0);
   endtask

   // Receiver: check accepted transactions, then choose next ready
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_result();
         rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_sentence_kinds();
      for (int k = 0; k < 6; k++)
         send_sentence(to_seq({kind_heads[k], ",123519,4807.038,N"}), TAIL_GOOD, k == 2);
      send_sentence(to_seq("GPGGB,1"), TAIL_GOOD, 0);   // near-miss header
      send_sentence(to_seq("GP"), TAIL_GOOD, 0);        // header cut by the star
   endtask

   task automatic test_line_framing();
      byte_seq_type q;
      send_byte(nmea_pkg::CHAR_NL);                      // empty line
      send_bytes(to_seq("GPGGA,1*00\n"));                // no leading dollar
      q = to_seq("GPGLL");
      q.insert(2, nmea_pkg::CHAR_NUL);                   // zero byte before star
      send_sentence(q, TAIL_GOOD, 0);
      send_sentence(to_seq("GNRMC,A"), TAIL_BAD, 0);
      send_sentence(to_seq("J"), TAIL_LOWER, 0);         // lowercase hex letter
      send_sentence(to_seq("GPRMC,V"), TAIL_NONE, 0);    // ends right after star
      send_sentence(to_seq("GPRMC,V"), TAIL_ONE, 0);     // only one hex byte
      // extreme bytes in the hex positions
      send_bytes('{nmea_pkg::CHAR_DOLLAR, nmea_pkg::CHAR_STAR, nmea_pkg::CHAR_NUL, 8'hFF,
                   nmea_pkg::CHAR_NL});
   endtask

   task automatic test_star_window();
      byte_seq_type q;
      // star at last index, then one past
      send_sentence(rand_text(nmea_pkg::SCAN_LIMIT_DEF - 2), TAIL_GOOD, 0);
      send_sentence(rand_text(nmea_pkg::SCAN_LIMIT_DEF - 1), TAIL_GOOD, 0);
      q = rand_text(90);                                           // no star at all
      q.push_front(nmea_pkg::CHAR_DOLLAR);
      q.push_back(nmea_pkg::CHAR_NL);
      send_bytes(q);
   endtask

   task automatic test_line_overflow();
      byte_seq_type q;
      // full store, then a plain byte that gets dropped, then an empty line
      q = rand_text(nmea_pkg::LINE_BYTES_DEF - 1);
      q.push_front(nmea_pkg::CHAR_DOLLAR);
      q.push_back(8'h58);
      q.push_back(nmea_pkg::CHAR_NL);
      send_bytes(q);
      // full store ended by a newline
      q = rand_text(nmea_pkg::LINE_BYTES_DEF);
      q.push_back(nmea_pkg::CHAR_NL);
      send_bytes(q);
      // one short of full
      q = rand_text(nmea_pkg::LINE_BYTES_DEF - 1);
      q.push_back(nmea_pkg::CHAR_NL);
      send_bytes(q);
      // valid sentence padded out to the full store
      q = build_sentence(to_seq("GPRMC,A"), TAIL_GOOD);
      while (q.size() < nmea_pkg::LINE_BYTES_DEF) q.push_back(CHAR_COMMA);
      q.push_back(8'hFF);
      send_bytes(q);
   endtask

   task automatic test_byte_extremes();
      send_sentence('{8'h80, 8'hFF, 8'h7F, 8'h01, 8'h5A}, TAIL_GOOD, 0);
      send_sentence(to_seq("$"), TAIL_GOOD, 1);          // second dollar is summed
   endtask

   task automatic test_random_lines(input int byte_budget);
      byte_seq_type q;
      int           stop_at;
      int           pick;
      stop_at = bytes_sent + byte_budget;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            // well-formed sentence, now and then a bad checksum
            q = {rand_header(), rand_text($urandom_range(0, 30))};
            send_sentence(q, ($urandom_range(0, 9) == 0) ? TAIL_BAD : TAIL_GOOD,
                          $urandom_range(0, 3) == 0);
         end else if (pick < 78) begin
            // broken sentence
            q = {rand_header(), rand_text($urandom_range(0, 20))};
            case ($urandom_range(0, 3))
               0: begin
                  q.insert($urandom_range(0, q.size() - 1), nmea_pkg::CHAR_NUL);
                  send_sentence(q, TAIL_GOOD, 0);
               end
               1: send_sentence(q, TAIL_LOWER, 0);
               2: send_sentence(q, TAIL_ONE, 0);
               default: send_sentence(q, TAIL_NONE, 0);
            endcase
         end else if (pick < 86) begin
            // around the end of the star window
            send_sentence(rand_text($urandom_range(nmea_pkg::SCAN_LIMIT_DEF - 7,
                                                   nmea_pkg::SCAN_LIMIT_DEF + 5)),
                          TAIL_GOOD, 0);
         end else if (pick < 96) begin
            q = rand_noise($urandom_range(0, 24));
            q.push_back(nmea_pkg::CHAR_NL);
            send_bytes(q);
         end else begin
            // about as long as the store, often long enough to fill it
            q = rand_noise($urandom_range(nmea_pkg::LINE_BYTES_DEF - 4,
                                          nmea_pkg::LINE_BYTES_DEF + 7));
            if ($urandom_range(0, 1)) q[0] = nmea_pkg::CHAR_DOLLAR;
            q.push_back(nmea_pkg::CHAR_NL);
            send_bytes(q);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      clear_line_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 19;
      rsp_idle_pct  = 87;
      test_sentence_kinds();
      test_line_framing();
      test_star_window();
      test_line_overflow();
      test_byte_extremes();
      test_random_lines(165);

      send_idle_pct = 87;
      rsp_idle_pct  = 19;
      test_random_lines(165);

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_random_lines(165);

      req_tvalid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d bytes streamed, %0d line results compared", bytes_sent, lines_checked);
      $display("%0d lines passed checksum, %0d ended by a full store, %0d mismatches",
               good_lines, overflow_lines, mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
